// ===== hw/rtl/palette_remap_nearest_scaler_defines.svh =====
// Assertion macros used by the checker file of the scaler.
`ifndef PALETTE_REMAP_NEAREST_SCALER_DEFINES_SVH
`define PALETTE_REMAP_NEAREST_SCALER_DEFINES_SVH

// Same-cycle implication, switched off while reset is held.
`define PRNS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("prns: same-cycle check failed");

// Next-cycle implication, switched off while reset is held.
`define PRNS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("prns: next-cycle check failed");

// Next-cycle implication that also runs through reset.
`define PRNS_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("prns: reset check failed");

`endif

// ===== hw/rtl/prns_pkg.sv =====
// Package: types, constants and the colour remap function of the scaler.
`default_nettype none
package prns_pkg;

  // store geometry
  localparam int SRC_DEPTH     = 65536;
  localparam int SRC_AW        = $clog2(SRC_DEPTH);
  localparam int PAL_DEPTH     = 256;
  localparam int PAL_AW        = $clog2(PAL_DEPTH);

  // colour ranges
  localparam logic [7:0] TOP_START    = 8'd16;
  localparam logic [7:0] BOTTOM_START = 8'd96;
  localparam logic [3:0] COLOR_CLAMP  = 4'd13;
  localparam logic [7:0] REVERSE_AT   = 8'd128;
  localparam logic [7:0] RANGE_LEN    = 8'd16;
  localparam logic [7:0] RANGE_LAST   = 8'd15;

  // output size limits
  localparam logic [9:0] OUT_MAX_WIDTH  = 10'd512;
  localparam logic [8:0] OUT_MAX_HEIGHT = 9'd256;

  // shared divider: 26-bit dividend (src_width << 16 or y*src_height), 10-bit divisor
  localparam int DIV_NW = 26;
  localparam int DIV_DW = 10;
  localparam int DIV_CW = $clog2(DIV_NW + 1);

  // request kinds carried in tuser
  typedef logic [1:0] func_t;
  localparam func_t FUNC_LOAD_TEX = 2'd0;
  localparam func_t FUNC_LOAD_PAL = 2'd1;
  localparam func_t FUNC_FETCH    = 2'd2;

  // configuration register indexes
  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t CFG_TOP_COLOR    = 3'd0;
  localparam cfg_idx_t CFG_BOTTOM_COLOR = 3'd1;
  localparam cfg_idx_t CFG_SRC_WIDTH    = 3'd2;
  localparam cfg_idx_t CFG_SRC_HEIGHT   = 3'd3;
  localparam cfg_idx_t CFG_ROW_PITCH    = 3'd4;
  localparam cfg_idx_t CFG_OUT_WIDTH    = 3'd5;
  localparam cfg_idx_t CFG_OUT_HEIGHT   = 3'd6;
  localparam cfg_idx_t CFG_INDEX_MODE   = 3'd7;

  function automatic logic [7:0] range_base(input logic [3:0] c);
    logic [3:0] cc;
    cc = (c > COLOR_CLAMP) ? COLOR_CLAMP : c;
    return {cc, 4'b0000};
  endfunction

  // A texel in either range maps to min(colour,13)*16 plus offset, reversed in the
  // upper half; bottom range is tested last so it wins on overlap.
  function automatic logic [7:0] remap(input logic [7:0] t, input logic [3:0] top_c,
                                       input logic [3:0] bot_c);
    logic [7:0] tb;
    logic [7:0] bb;
    logic [7:0] ot;
    logic [7:0] ob;
    logic [7:0] v;
    tb = range_base(top_c);
    bb = range_base(bot_c);
    ot = t - TOP_START;
    ob = t - BOTTOM_START;
    v  = t;
    if (ot < RANGE_LEN) begin
      v = (tb < REVERSE_AT) ? tb + ot : tb + RANGE_LAST - ot;
    end
    if (ob < RANGE_LEN) begin
      v = (bb < REVERSE_AT) ? bb + ob : bb + RANGE_LAST - ob;
    end
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/prns_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by the row and step divides.
`default_nettype none
module prns_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [prns_pkg::DIV_NW-1:0] dividend,
  input  wire logic [prns_pkg::DIV_DW-1:0] divisor,
  output logic                             done,
  output logic [prns_pkg::DIV_NW-1:0]      quotient
);

  logic                        run_r;
  logic                        done_r;
  logic [prns_pkg::DIV_CW-1:0] cnt_r;
  logic [prns_pkg::DIV_NW-1:0] quo_r;
  logic [prns_pkg::DIV_NW-1:0] quo_nxt;
  logic [prns_pkg::DIV_DW-1:0] rem_r;
  logic [prns_pkg::DIV_DW-1:0] rem_nxt;
  logic [prns_pkg::DIV_DW-1:0] den_r;
  logic [prns_pkg::DIV_DW:0]   rem_sh;
  logic [prns_pkg::DIV_DW:0]   rem_sub;
  logic                        ge;

  always_comb begin
    rem_sh  = {rem_r, quo_r[prns_pkg::DIV_NW-1]};
    rem_sub = rem_sh - {1'b0, den_r};
    ge      = rem_sh >= {1'b0, den_r};
    rem_nxt = ge ? rem_sub[prns_pkg::DIV_DW-1:0] : rem_sh[prns_pkg::DIV_DW-1:0];
    quo_nxt = {quo_r[prns_pkg::DIV_NW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
        quo_r <= dividend;
        rem_r <= '0;
        den_r <= divisor;
      end else if (run_r) begin
        rem_r <= rem_nxt;
        quo_r <= quo_nxt;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == prns_pkg::DIV_CW'(prns_pkg::DIV_NW - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

// ===== hw/rtl/palette_remap_nearest_scaler.sv =====
// Nearest-neighbour texture resampler with palette remap: top level.
//
// Channels: in_* carries requests (tuser = kind: load texel, load palette
// word, fetch pixel), out_* carries one pixel per fetch that lies inside the
// output image, cfg_* writes the eight configuration registers (always ready,
// write only while the block is idle).
// Loads write the store at the accepting edge, and in_tready stays high.
// A fetch runs the shared one-bit-per-cycle divider twice (row =
// y*src_h/out_h, then the 16.16 column step), then a multiply, an address
// step, a texel read and a palette read before out_tvalid. in_tready is low
// during that time, so no new request is taken while a fetch is busy;
// a fetch outside the image is dropped at acceptance, in_tready staying high.
// Results sit in an output register, so the next request is taken while a
// pixel waits; if the receiver stalls, the next fetch holds in its last step
// until the register frees.
// Reset (rst_n low, synchronous) returns config to defaults and empties the
// output register; texel and palette stores are undefined until written.
`default_nettype none
module palette_remap_nearest_scaler (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in_tdata: load_addr[15:0], load_data[47:16], pix_x[56:48], pix_y[64:57], zero pad
  input  wire logic [71:0] in_tdata,
  // in_tuser: func[1:0]
  input  wire logic [1:0]  in_tuser,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // out_tdata: pixel[31:0], at_x[40:32], at_y[48:41], zero pad
  output logic [55:0]      out_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [9:0]  cfg_data
);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_ROWDIV  = 7'b0000010,
    S_STEPDIV = 7'b0000100,
    S_MUL     = 7'b0001000,
    S_ADDR    = 7'b0010000,
    S_TEX     = 7'b0100000,
    S_PAL     = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [3:0] top_color_r;
  logic [3:0] bottom_color_r;
  logic [9:0] src_width_r;
  logic [8:0] src_height_r;
  logic [9:0] row_pitch_r;
  logic [9:0] out_width_r;
  logic [8:0] out_height_r;
  logic       index_mode_r;

  // request fields
  logic [15:0]          load_addr;
  logic [31:0]          load_data;
  logic [8:0]           pix_x;
  logic [7:0]           pix_y;
  prns_pkg::func_t      func;
  logic                 in_acc;

  logic [9:0] ow;
  logic [8:0] oh;
  logic       in_image;

  // fetch datapath
  logic [8:0]                   x_r;
  logic [7:0]                   y_r;
  logic [8:0]                   row_r;
  logic [prns_pkg::DIV_NW-1:0]  step_r;
  logic [15:0]                  col_r;
  logic [prns_pkg::SRC_AW-1:0]  rp_r;
  logic [7:0]                   idx_r;
  logic [34:0]                  prod;
  logic [31:0]                  frac;
  logic [18:0]                  rp_full;

  logic                         div_start;
  logic [prns_pkg::DIV_NW-1:0]  div_dividend;
  logic [prns_pkg::DIV_DW-1:0]  div_divisor;
  logic                         div_done;
  logic [prns_pkg::DIV_NW-1:0]  div_quo;

  // stores
  logic [7:0]  tex_mem [prns_pkg::SRC_DEPTH];
  logic [31:0] pal_mem [prns_pkg::PAL_DEPTH];
  logic [7:0]  tex_q_r;
  logic [31:0] pal_q_r;
  logic        tex_we;
  logic        pal_we;
  logic        tex_re;
  logic        pal_re;
  logic [prns_pkg::SRC_AW-1:0] tex_raddr;
  logic [7:0]  remap_idx;

  logic        out_tvalid_r;
  logic [55:0] out_tdata_r;
  logic        out_free;
  logic        out_load;

  assign load_addr = in_tdata[15:0];
  assign load_data = in_tdata[47:16];
  assign pix_x     = in_tdata[56:48];
  assign pix_y     = in_tdata[64:57];
  assign func      = in_tuser;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // effective output size: zero acts as one, large values saturate
  always_comb begin
    ow = (out_width_r == 10'd0) ? 10'd1 : out_width_r;
    if (ow > prns_pkg::OUT_MAX_WIDTH) ow = prns_pkg::OUT_MAX_WIDTH;
    oh = (out_height_r == 9'd0) ? 9'd1 : out_height_r;
    if (oh > prns_pkg::OUT_MAX_HEIGHT) oh = prns_pkg::OUT_MAX_HEIGHT;
    in_image = ({1'b0, pix_x} < ow) && ({1'b0, pix_y} < oh);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_color_r    <= 4'd0;
      bottom_color_r <= 4'd0;
      src_width_r    <= 10'd296;
      src_height_r   <= 9'd194;
      row_pitch_r    <= 10'd320;
      out_width_r    <= 10'd512;
      out_height_r   <= 9'd256;
      index_mode_r   <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_addr)
        prns_pkg::CFG_TOP_COLOR:    top_color_r    <= cfg_data[3:0];
        prns_pkg::CFG_BOTTOM_COLOR: bottom_color_r <= cfg_data[3:0];
        prns_pkg::CFG_SRC_WIDTH:    src_width_r    <= cfg_data;
        prns_pkg::CFG_SRC_HEIGHT:   src_height_r   <= cfg_data[8:0];
        prns_pkg::CFG_ROW_PITCH:    row_pitch_r    <= cfg_data;
        prns_pkg::CFG_OUT_WIDTH:    out_width_r    <= cfg_data;
        prns_pkg::CFG_OUT_HEIGHT:   out_height_r   <= cfg_data[8:0];
        prns_pkg::CFG_INDEX_MODE:   index_mode_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign out_free = !out_tvalid_r || out_tready;

  always_comb begin
    state_nxt    = state_r;
    div_start    = 1'b0;
    div_dividend = prns_pkg::DIV_NW'({src_width_r, 16'h0000});
    div_divisor  = ow;
    tex_we       = 1'b0;
    pal_we       = 1'b0;
    tex_re       = 1'b0;
    pal_re       = 1'b0;
    out_load     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        div_dividend = prns_pkg::DIV_NW'({9'd0, pix_y} * {8'd0, src_height_r});
        div_divisor  = prns_pkg::DIV_DW'(oh);
        if (in_acc) begin
          case (func)
            prns_pkg::FUNC_LOAD_TEX: tex_we = 1'b1;
            prns_pkg::FUNC_LOAD_PAL: pal_we = 1'b1;
            prns_pkg::FUNC_FETCH: begin
              if (in_image) begin
                div_start = 1'b1;
                state_nxt = S_ROWDIV;
              end
            end
            default: ;
          endcase
        end
      end
      S_ROWDIV: begin
        if (div_done) begin
          div_start = 1'b1;
          state_nxt = S_STEPDIV;
        end
      end
      S_STEPDIV: begin
        if (div_done) state_nxt = S_MUL;
      end
      S_MUL:  state_nxt = S_ADDR;
      S_ADDR: begin
        tex_re    = 1'b1;
        state_nxt = S_TEX;
      end
      S_TEX: begin
        pal_re    = 1'b1;
        state_nxt = S_PAL;
      end
      S_PAL: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  prns_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  // 16.16 column position, wraps at 32 bits
  always_comb begin
    prod    = 35'(x_r) * 35'(step_r);
    frac    = prod[31:0] + 32'(step_r[prns_pkg::DIV_NW-1:1]);
    rp_full = row_r * row_pitch_r;
  end

  assign tex_raddr = rp_r + col_r[prns_pkg::SRC_AW-1:0];
  assign remap_idx = prns_pkg::remap(tex_q_r, top_color_r, bottom_color_r);

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_acc) begin
      x_r <= pix_x;
      y_r <= pix_y;
    end
    if (state_r == S_ROWDIV && div_done) row_r <= div_quo[8:0];
    if (state_r == S_STEPDIV && div_done) step_r <= div_quo;
    if (state_r == S_MUL) begin
      col_r <= frac[31:16];
      rp_r  <= rp_full[prns_pkg::SRC_AW-1:0];
    end
    if (state_r == S_TEX) idx_r <= remap_idx;
  end

  always_ff @(posedge clk) begin
    if (tex_we) tex_mem[load_addr[prns_pkg::SRC_AW-1:0]] <= load_data[7:0];
    if (tex_re) tex_q_r <= tex_mem[tex_raddr];
  end

  always_ff @(posedge clk) begin
    if (pal_we) pal_mem[load_addr[prns_pkg::PAL_AW-1:0]] <= load_data;
    if (pal_re) pal_q_r <= pal_mem[remap_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= {7'b0, y_r, x_r,
                      index_mode_r ? {24'b0, idx_r} : pal_q_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule
`default_nettype wire

// ===== hw/rtl/prns_checker.sv =====
// Port-level checks of the scaler, bound to the top level.
`default_nettype none
`include "palette_remap_nearest_scaler_defines.svh"
module prns_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic [1:0]  in_tuser,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [55:0] out_tdata,
  input wire logic        out_tvalid,
  input wire logic        out_tready
);

  // a stalled result keeps its data
  `PRNS_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // reset empties the output register
  `PRNS_ASSERT_RST(a_rst_empty, !rst_n, !out_tvalid)

  // loads and other non-fetch requests leave in_tready high and make no result
  `PRNS_ASSERT_NEXT(a_load_quick, in_tvalid && in_tready && in_tuser != prns_pkg::FUNC_FETCH,
                    in_tready && !$rose(out_tvalid))

  // a new result only comes out of a busy fetch
  `PRNS_ASSERT_IMPL(a_res_from_fetch, $rose(out_tvalid), $past(!in_tready))

endmodule

bind palette_remap_nearest_scaler prns_checker u_prns_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tuser   (in_tuser),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);
`default_nettype wire

// ===== test/tb_palette_remap_nearest_scaler.sv =====
// Self-checking bench for the palette-remapping nearest-neighbour scaler.
module tb_palette_remap_nearest_scaler;
  timeunit 1ns;
  timeprecision 1ps;
  import prns_pkg::*;

  localparam int CYCLE_LIMIT = 4_000_000;
  // leave margin for a fetch to finish before touching config
  localparam int SETTLE_CYCLES = 80;
  localparam func_t FUNC_SPARE = 2'd3;

  typedef struct {
    func_t       func;
    logic [15:0] addr;
    logic [31:0] data;
    logic [8:0]  x;
    logic [7:0]  y;
  } req_t;

  typedef struct {
    logic [31:0] pixel;
    logic [8:0]  x;
    logic [7:0]  y;
  } pixel_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic [71:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] out_tdata;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_addr = '0;
  logic [9:0]  cfg_data = '0;

  palette_remap_nearest_scaler dut (.*);

  // shadow configuration, reset values
  logic [3:0] top_c    = 4'd0;
  logic [3:0] bot_c    = 4'd0;
  logic [9:0] src_w    = 10'd296;
  logic [8:0] src_h    = 9'd194;
  logic [9:0] pitch    = 10'd320;
  logic [9:0] out_w    = 10'd512;
  logic [8:0] out_h    = 9'd256;
  logic       idx_mode = 1'b0;

  // stores as seen at acceptance
  logic [7:0]  tex_mem [65536];
  logic [31:0] pal_mem [256];
  // stores as planned while requests are queued
  bit [7:0] plan_tex [65536];
  bit       tex_ok [65536];
  bit       pal_ok [256];

  req_t   pending [$];
  pixel_t pixel_due [$];
  int     reqs_left = 0;
  int     mismatches = 0;
  bit     in_calm = 1'b0;
  bit     out_calm = 1'b0;
  int unsigned next_cfg [8];

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int pick_gap(input bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 90);
  endfunction

  function automatic int unsigned eff_w();
    if (out_w == 0) return 1;
    if (out_w > OUT_MAX_WIDTH) return OUT_MAX_WIDTH;
    return out_w;
  endfunction

  function automatic int unsigned eff_h();
    if (out_h == 0) return 1;
    if (out_h > OUT_MAX_HEIGHT) return OUT_MAX_HEIGHT;
    return out_h;
  endfunction

  // source texel address of an output pixel; 0 when outside the image
  function automatic bit locate(input logic [8:0] x, input logic [7:0] y,
                                output logic [15:0] a);
    int unsigned ow, oh, row, step, pos, sw;
    ow = eff_w();
    oh = eff_h();
    a = '0;
    if (x >= ow || y >= oh) return 0;
    sw = src_w;
    row = (y * src_h) / oh;
    step = (sw << 16) / ow;
    pos = (step >> 1) + x * step;
    a = 16'(row * pitch + (pos >> 16));
    return 1;
  endfunction

  function automatic logic [7:0] recolour(input logic [7:0] t);
    logic [7:0] tb, bb, v;
    tb = {((top_c > COLOR_CLAMP) ? COLOR_CLAMP : top_c), 4'h0};
    bb = {((bot_c > COLOR_CLAMP) ? COLOR_CLAMP : bot_c), 4'h0};
    v = t;
    for (int i = 0; i < 16; i++) begin
      if (8'(TOP_START + i) == t) v = (tb < REVERSE_AT) ? 8'(tb + i) : 8'(tb + 15 - i);
      if (8'(BOTTOM_START + i) == t) v = (bb < REVERSE_AT) ? 8'(bb + i) : 8'(bb + 15 - i);
    end
    return v;
  endfunction

  function automatic int unsigned pick_size(input int unsigned hi, input int unsigned ones);
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 1;
      2: return hi;
      3: return ones;
      default: return $urandom_range(1, hi);
    endcase
  endfunction

  task automatic push_req(input req_t r);
    pending.push_back(r);
    reqs_left++;
  endtask

  task automatic gen_load_tex(input logic [15:0] a, input logic [31:0] d);
    req_t r;
    r.func = FUNC_LOAD_TEX;
    r.addr = a;
    r.data = d;
    r.x = 9'($urandom);
    r.y = 8'($urandom);
    plan_tex[a] = d[7:0];
    tex_ok[a] = 1'b1;
    push_req(r);
  endtask

  task automatic gen_load_pal(input logic [15:0] a, input logic [31:0] d);
    req_t r;
    r.func = FUNC_LOAD_PAL;
    r.addr = a;
    r.data = d;
    r.x = 9'($urandom);
    r.y = 8'($urandom);
    pal_ok[a[7:0]] = 1'b1;
    push_req(r);
  endtask

  task automatic gen_spare();
    req_t r;
    r.func = FUNC_SPARE;
    r.addr = 16'($urandom);
    r.data = $urandom;
    r.x = 9'($urandom);
    r.y = 8'($urandom);
    push_req(r);
  endtask

  // a fetch, preceded by whatever loads keep it off unwritten entries
  task automatic gen_fetch(input logic [8:0] x, input logic [7:0] y);
    logic [15:0] a;
    logic [31:0] d;
    logic [7:0]  idx;
    int unsigned roll;
    req_t r;
    if (locate(x, y, a)) begin
      if (!tex_ok[a]) begin
        roll = $urandom_range(0, 9);
        d = $urandom;
        if (roll < 2) d[7:0] = 8'(TOP_START + $urandom_range(0, 15));
        else if (roll < 4) d[7:0] = 8'(BOTTOM_START + $urandom_range(0, 15));
        gen_load_tex(a, d);
      end
      idx = recolour(plan_tex[a]);
      if (!idx_mode && !pal_ok[idx]) gen_load_pal({8'($urandom), idx}, $urandom);
    end
    r.func = FUNC_FETCH;
    r.addr = 16'($urandom);
    r.data = $urandom;
    r.x = x;
    r.y = y;
    push_req(r);
  endtask

  task automatic cfg_write(input cfg_idx_t idx, input logic [9:0] val);
    cfg_valid <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_TOP_COLOR:    top_c = val[3:0];
      CFG_BOTTOM_COLOR: bot_c = val[3:0];
      CFG_SRC_WIDTH:    src_w = val;
      CFG_SRC_HEIGHT:   src_h = val[8:0];
      CFG_ROW_PITCH:    pitch = val;
      CFG_OUT_WIDTH:    out_w = val;
      CFG_OUT_HEIGHT:   out_h = val[8:0];
      CFG_INDEX_MODE:   idx_mode = val[0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_setting();
    for (int i = 0; i < 8; i++) cfg_write(cfg_idx_t'(i), 10'(next_cfg[i]));
  endtask

  // a dropped fetch leaves nothing behind, so allow a full latency on top
  task automatic wait_idle();
    do @(posedge clk); while (reqs_left != 0 || pixel_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // request driver
  req_t cur;
  int   in_gap = 0;
  always @(posedge clk) begin
    logic [15:0] a;
    logic [7:0]  idx;
    pixel_t      p;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        case (cur.func)
          FUNC_LOAD_TEX: tex_mem[cur.addr] = cur.data[7:0];
          FUNC_LOAD_PAL: pal_mem[cur.addr[7:0]] = cur.data;
          FUNC_FETCH: begin
            if (locate(cur.x, cur.y, a)) begin
              idx = recolour(tex_mem[a]);
              p.pixel = idx_mode ? {24'h0, idx} : pal_mem[idx];
              p.x = cur.x;
              p.y = cur.y;
              pixel_due.push_back(p);
            end
          end
          default: ;
        endcase
        reqs_left--;
      end
      if (!(in_tvalid && !in_tready)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (pending.size() > 0) begin
          cur = pending.pop_front();
          in_tuser <= cur.func;
          in_tdata <= {7'b0, cur.y, cur.x, cur.data, cur.addr};
          in_tvalid <= 1'b1;
          in_gap = pick_gap(in_calm);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  int out_stall = 0;
  always @(posedge clk) begin
    pixel_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (pixel_due.size() == 0) begin
          mismatches++;
          $display("%0t unexpected pixel: expected none, got %h at (%0d,%0d)", $time,
                   out_tdata[31:0], out_tdata[40:32], out_tdata[48:41]);
        end else begin
          want = pixel_due.pop_front();
          if (out_tdata[31:0] !== want.pixel) begin
            mismatches++;
            $display("%0t pixel at (%0d,%0d): expected %h, got %h", $time,
                     want.x, want.y, want.pixel, out_tdata[31:0]);
          end
          if (out_tdata[40:32] !== want.x) begin
            mismatches++;
            $display("%0t at_x: expected %0d, got %0d", $time, want.x, out_tdata[40:32]);
          end
          if (out_tdata[48:41] !== want.y) begin
            mismatches++;
            $display("%0t at_y: expected %0d, got %0d", $time, want.y, out_tdata[48:41]);
          end
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        out_stall = pick_gap(out_calm);
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int unsigned roll;
    logic [8:0]  x0;
    logic [7:0]  y0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset configuration, palette index from low address bits only
    gen_load_pal(16'h0000, 32'h0000_0000);
    gen_load_pal(16'hFFFF, 32'hFFFF_FFFF);
    gen_load_tex(16'h0000, 32'hFFFF_FF10);
    gen_load_tex(16'hFFFF, 32'h0000_00FF);
    gen_fetch(9'd0, 8'd0);
    gen_fetch(9'd511, 8'd255);
    gen_spare();
    gen_fetch(9'd100, 8'd50);
    wait_idle();

    // zero output size acts as one; colours clamp and reverse; index output
    next_cfg = '{15, 8, 1023, 511, 1023, 0, 0, 1};
    apply_setting();
    gen_load_tex(16'd511, 32'h5A5A_A56F);
    gen_fetch(9'd0, 8'd0);
    gen_fetch(9'd1, 8'd0);
    gen_fetch(9'd0, 8'd1);
    gen_fetch(9'd511, 8'd255);
    gen_spare();
    wait_idle();

    // output size saturates; source address wraps
    next_cfg = '{7, 13, 1023, 511, 1023, 1023, 511, 0};
    apply_setting();
    gen_fetch(9'd511, 8'd255);
    gen_fetch(9'd0, 8'd255);
    gen_fetch(9'd300, 8'd200);
    gen_fetch(9'd0, 8'd0);
    wait_idle();

    for (int ph = 0; ph < 5; ph++) begin
      next_cfg[0] = $urandom_range(0, 1023);
      next_cfg[1] = $urandom_range(0, 1023);
      next_cfg[2] = pick_size(512, 1023);
      next_cfg[3] = pick_size(256, 511);
      next_cfg[4] = pick_size(512, 1023);
      next_cfg[5] = pick_size(512, 1023);
      next_cfg[6] = pick_size(256, 511);
      next_cfg[7] = $urandom_range(0, 1023);
      apply_setting();
      in_calm = (ph == 1);
      out_calm = (ph == 2);
      for (int n = 0; n < 80; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 45) begin
          gen_fetch(9'($urandom_range(0, eff_w() - 1)), 8'($urandom_range(0, eff_h() - 1)));
        end else if (roll < 55) begin
          gen_fetch(9'($urandom), 8'($urandom));
        end else if (roll < 70) begin
          gen_load_tex(16'($urandom), $urandom);
        end else if (roll < 80) begin
          gen_load_pal(16'($urandom), $urandom);
        end else if (roll < 85) begin
          gen_spare();
        end else begin
          // short scanline, may run off the right edge
          x0 = 9'($urandom_range(0, eff_w() - 1));
          y0 = 8'($urandom_range(0, eff_h() - 1));
          for (int k = 0; k < 6; k++) gen_fetch(9'(x0 + k), y0);
        end
      end
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
